// File: design/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros sample on clk_i and
// stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSRK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define LSRK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define LSRK_ASSERT(lbl, prop)
`define LSRK_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: design/lsrk_pkg.sv
`timescale 1ns / 1ps

package lsrk_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_READ   = 3'd1,
    MODE_INIT   = 3'd2,
    MODE_STAGE  = 3'd3,
    MODE_FINAL  = 3'd4,
    MODE_ERROR  = 3'd5,
    MODE_UNDO   = 3'd6,
    MODE_RDLOW  = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    CFG_COEF_A     = 3'd0,
    CFG_COEF_B     = 3'd1,
    CFG_COEF_C     = 3'd2,
    CFG_COEF_BETA  = 3'd3,
    CFG_COEF_DELTA = 3'd4,
    CFG_STEP_DT    = 3'd5,
    CFG_ERR_EPS    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LATCH,
    ST_CALC,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam int SUM_W = 68;
  localparam int DVD_W = 50;
  localparam int DVS_W = 33;
  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic [31:0] r;
    if (x > 68'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/lsrk_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lsrk_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lsrk_pkg::DVD_W-1:0]    dividend_i,
  input  logic [lsrk_pkg::DVS_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [lsrk_pkg::DVD_W-1:0]    quot_o
);

  localparam int CW = $clog2(lsrk_pkg::DVD_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [lsrk_pkg::DVS_W-1:0]    rem_q;
  logic [lsrk_pkg::DVD_W-1:0]    quo_q;
  logic [lsrk_pkg::DVS_W-1:0]    dvs_q;
  logic [lsrk_pkg::DVS_W:0]      rem_sh;
  logic [lsrk_pkg::DVS_W+1:0]    diff;

  assign rem_sh = {rem_q, quo_q[lsrk_pkg::DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(lsrk_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[lsrk_pkg::DVS_W+1]) begin
        rem_q <= diff[lsrk_pkg::DVS_W-1:0];
        quo_q <= {quo_q[lsrk_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[lsrk_pkg::DVS_W-1:0];
        quo_q <= {quo_q[lsrk_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: design/low_storage_rk_stage_engine.sv
`timescale 1ns / 1ps
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+-------------------------------------
// input     | in_valid_i / in_ready_o           | mode_i, element_index_i, value_in_i,
//           |                                   | restart_i
// output    | out_valid_o / out_ready_i         | value_out_o, err_abs_o, err_rel_o
// config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// One beat is worked on at a time. A beat with an index in range passes through ST_READ,
// ST_LATCH and ST_CALC; load, init, undo, stage and finalise then go through ST_WRITE, and
// error mode with a positive norm waits in ST_DIV on the one-bit-per-cycle divider for the
// relative error. Every beat ends in ST_DONE. Stage and finalise run every product through
// one shared 33x33 multiplier. Reset clears the sequencer, the maxima, the init flag, the
// output valid and the coefficients; the stores are not cleared. A result waits in the
// output register, and the next beat may be taken meanwhile; it then stalls at its end until
// the output register is free. in_ready_o rises together with out_valid_o.
`include "assert_macros.svh"

module low_storage_rk_stage_engine #(
  parameter int ELEMENTS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [11:0]        element_index_i,
  input  logic signed [31:0] value_in_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_out_o,
  output logic [30:0]        err_abs_o,
  output logic [30:0]        err_rel_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int SW = lsrk_pkg::SUM_W;

  // Configuration registers.
  logic [31:0] coef_a_q, coef_b_q, coef_c_q, coef_beta_q, coef_delta_q, step_dt_q;
  logic [30:0] err_eps_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q     <= '0;
      coef_b_q     <= '0;
      coef_c_q     <= '0;
      coef_beta_q  <= '0;
      coef_delta_q <= '0;
      step_dt_q    <= '0;
      err_eps_q    <= '0;
    end else if (cfg_we) begin
      case (lsrk_pkg::cfg_idx_e'(paddr[4:2]))
        lsrk_pkg::CFG_COEF_A:     coef_a_q     <= pwdata;
        lsrk_pkg::CFG_COEF_B:     coef_b_q     <= pwdata;
        lsrk_pkg::CFG_COEF_C:     coef_c_q     <= pwdata;
        lsrk_pkg::CFG_COEF_BETA:  coef_beta_q  <= pwdata;
        lsrk_pkg::CFG_COEF_DELTA: coef_delta_q <= pwdata;
        lsrk_pkg::CFG_STEP_DT:    step_dt_q    <= pwdata;
        lsrk_pkg::CFG_ERR_EPS:    err_eps_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lsrk_pkg::cfg_idx_e'(paddr[4:2]))
      lsrk_pkg::CFG_COEF_A:     prdata = coef_a_q;
      lsrk_pkg::CFG_COEF_B:     prdata = coef_b_q;
      lsrk_pkg::CFG_COEF_C:     prdata = coef_c_q;
      lsrk_pkg::CFG_COEF_BETA:  prdata = coef_beta_q;
      lsrk_pkg::CFG_COEF_DELTA: prdata = coef_delta_q;
      lsrk_pkg::CFG_STEP_DT:    prdata = step_dt_q;
      lsrk_pkg::CFG_ERR_EPS:    prdata = {1'b0, err_eps_q};
      default:                  prdata = '0;
    endcase
  end

  // Sequencer state and the captured beat.
  lsrk_pkg::state_e state_q, state_d;
  lsrk_pkg::mode_e  mode_q;
  logic [11:0]      idx_q;
  logic [31:0]      vin_q;
  logic             restart_q;
  logic             rng_q;
  logic [3:0]       cnt_q;
  logic             in_acc;
  logic             out_free;

  // Working copies of the element.
  logic [31:0] s_q, a_q, t_q, d_q;
  logic [31:0] s_rd_q, a_rd_q, t_rd_q;

  logic             accum_valid_q;
  logic [30:0]      max_abs_q, max_rel_q;
  logic             out_valid_q;
  logic [31:0]      value_out_q;
  logic [30:0]      err_abs_q, err_rel_q;

  // Shared multiplier with its product register and the accumulator.
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] prod_q;
  logic signed [SW-1:0] sum_q;
  logic               sum_clr, sum_add, bias_dt;
  logic signed [SW-1:0] prod_ext;

  // Error-mode terms.
  logic signed [32:0] diff;
  logic [32:0]        err_e;
  logic signed [33:0] norm_sum;
  logic [30:0]        cand_abs;
  logic [30:0]        cand_rel_div;
  logic [30:0]        base_abs, base_rel;

  logic               div_start, div_busy, div_done;
  logic [lsrk_pkg::DVD_W-1:0] div_quot;

  logic               st_we, acc_we, start_we;
  logic [AW-1:0]      addr;
  logic [31:0]        st_wd, acc_wd;
  logic [31:0]        inc_sat;
  logic signed [SW-1:0] acc_inc_sum;

  assign in_ready_o = (state_q == lsrk_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign addr       = AW'(idx_q);

  // Next state and control strobes.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    st_we     = 1'b0;
    acc_we    = 1'b0;
    start_we  = 1'b0;
    case (state_q)
      lsrk_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (32'(element_index_i) < 32'(ELEMENTS)) ? lsrk_pkg::ST_READ
                                                          : lsrk_pkg::ST_DONE;
        end
      end
      lsrk_pkg::ST_READ:  state_d = lsrk_pkg::ST_LATCH;
      lsrk_pkg::ST_LATCH: state_d = lsrk_pkg::ST_CALC;
      lsrk_pkg::ST_CALC: begin
        case (mode_q)
          lsrk_pkg::MODE_READ, lsrk_pkg::MODE_RDLOW: state_d = lsrk_pkg::ST_DONE;
          lsrk_pkg::MODE_STAGE: begin
            if (cnt_q == 4'd8) state_d = lsrk_pkg::ST_WRITE;
          end
          lsrk_pkg::MODE_FINAL: begin
            if (cnt_q == 4'd4) state_d = lsrk_pkg::ST_WRITE;
          end
          lsrk_pkg::MODE_ERROR: begin
            if (norm_sum > 34'sd0) begin
              div_start = 1'b1;
              state_d   = lsrk_pkg::ST_DIV;
            end else begin
              state_d = lsrk_pkg::ST_DONE;
            end
          end
          default: state_d = lsrk_pkg::ST_WRITE;
        endcase
      end
      lsrk_pkg::ST_DIV: begin
        if (div_done) state_d = lsrk_pkg::ST_DONE;
      end
      lsrk_pkg::ST_WRITE: begin
        case (mode_q)
          lsrk_pkg::MODE_LOAD, lsrk_pkg::MODE_UNDO: st_we = 1'b1;
          lsrk_pkg::MODE_INIT: begin
            acc_we   = 1'b1;
            start_we = 1'b1;
          end
          lsrk_pkg::MODE_STAGE: begin
            st_we  = 1'b1;
            acc_we = 1'b1;
          end
          lsrk_pkg::MODE_FINAL: acc_we = 1'b1;
          default: ;
        endcase
        state_d = lsrk_pkg::ST_DONE;
      end
      lsrk_pkg::ST_DONE: begin
        if (out_free) state_d = lsrk_pkg::ST_IDLE;
      end
      default: state_d = lsrk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsrk_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == lsrk_pkg::ST_CALC) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Multiplier operand schedule. A product issued in one cycle is added
  // into the accumulator in the next.
  always_comb begin
    mul_x   = '0;
    mul_y   = '0;
    sum_clr = 1'b0;
    sum_add = 1'b0;
    bias_dt = 1'b0;
    if (state_q == lsrk_pkg::ST_CALC && mode_q == lsrk_pkg::MODE_STAGE) begin
      case (cnt_q)
        4'd0: begin
          mul_x = $signed({1'b0, step_dt_q});
          mul_y = $signed({vin_q[31], vin_q});
        end
        4'd1: begin
          mul_x   = $signed({coef_delta_q[31], coef_delta_q});
          mul_y   = $signed({s_q[31], s_q});
          sum_clr = 1'b1;
          bias_dt = 1'b1;
        end
        4'd2: sum_clr = 1'b1;
        4'd3: begin
          mul_x = $signed({coef_a_q[31], coef_a_q});
          mul_y = $signed({s_q[31], s_q});
        end
        4'd4: begin
          mul_x   = $signed({coef_b_q[31], coef_b_q});
          mul_y   = $signed({a_q[31], a_q});
          sum_clr = 1'b1;
        end
        4'd5: begin
          mul_x   = $signed({coef_c_q[31], coef_c_q});
          mul_y   = $signed({t_q[31], t_q});
          sum_add = 1'b1;
        end
        4'd6: begin
          mul_x   = $signed({coef_beta_q[31], coef_beta_q});
          mul_y   = $signed({d_q[31], d_q});
          sum_add = 1'b1;
        end
        4'd7: sum_add = 1'b1;
        default: ;
      endcase
    end else if (state_q == lsrk_pkg::ST_CALC && mode_q == lsrk_pkg::MODE_FINAL) begin
      case (cnt_q)
        4'd0: begin
          mul_x = $signed({coef_a_q[31], coef_a_q});
          mul_y = $signed({s_q[31], s_q});
        end
        4'd1: begin
          mul_x   = $signed({coef_b_q[31], coef_b_q});
          mul_y   = $signed({a_q[31], a_q});
          sum_clr = 1'b1;
        end
        4'd2: begin
          mul_x   = $signed({coef_c_q[31], coef_c_q});
          mul_y   = $signed({t_q[31], t_q});
          sum_add = 1'b1;
        end
        4'd3: sum_add = 1'b1;
        default: ;
      endcase
    end
  end

  assign prod_ext = SW'(prod_q);

  // Rounding half up: the bias is added once, when the sum starts.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_x * mul_y;
    if (sum_clr) begin
      sum_q <= prod_ext + (bias_dt ? (SW'(1) <<< 23) : (SW'(1) <<< 27));
    end else if (sum_add) begin
      sum_q <= sum_q + prod_ext;
    end
  end

  assign inc_sat     = lsrk_pkg::sat32(sum_q >>> 28);
  assign acc_inc_sum = SW'($signed(a_q)) + SW'($signed(inc_sat));

  // Error terms from the latched element.
  assign diff     = $signed({s_q[31], s_q}) - $signed({a_q[31], a_q});
  assign err_e    = diff[32] ? 33'(-diff) : 33'(diff);
  assign norm_sum = 34'($signed(s_q)) + 34'($signed(t_q)) + $signed({3'b000, err_eps_q});
  assign cand_abs = (err_e > 33'(lsrk_pkg::SAT31)) ? lsrk_pkg::SAT31 : err_e[30:0];
  assign cand_rel_div = (div_quot > lsrk_pkg::DVD_W'(lsrk_pkg::SAT31)) ? lsrk_pkg::SAT31
                                                                      : div_quot[30:0];
  assign base_abs = restart_q ? '0 : max_abs_q;
  assign base_rel = restart_q ? '0 : max_rel_q;

  lsrk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({err_e, 17'b0}),
    .divisor_i  (norm_sum[32:0]),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Beat capture and element working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q    <= lsrk_pkg::mode_e'(mode_i);
      idx_q     <= element_index_i;
      vin_q     <= value_in_i;
      restart_q <= restart_i;
      rng_q     <= (32'(element_index_i) < 32'(ELEMENTS));
    end
    if (state_q == lsrk_pkg::ST_LATCH) begin
      s_q <= s_rd_q;
      a_q <= a_rd_q;
      t_q <= t_rd_q;
    end else if (state_q == lsrk_pkg::ST_CALC) begin
      case (mode_q)
        lsrk_pkg::MODE_LOAD: s_q <= vin_q;
        lsrk_pkg::MODE_UNDO: s_q <= t_q;
        lsrk_pkg::MODE_STAGE: begin
          if (cnt_q == 4'd2) d_q <= lsrk_pkg::sat32(sum_q >>> 24);
          if (cnt_q == 4'd3) a_q <= lsrk_pkg::sat32(acc_inc_sum);
          if (cnt_q == 4'd8) s_q <= lsrk_pkg::sat32(sum_q >>> 28);
        end
        lsrk_pkg::MODE_FINAL: begin
          if (cnt_q == 4'd4) a_q <= lsrk_pkg::sat32(sum_q >>> 28);
        end
        default: ;
      endcase
    end
  end

  // Element stores.
  logic [31:0] state_mem [ELEMENTS];
  logic [31:0] accum_mem [ELEMENTS];
  logic [31:0] start_mem [ELEMENTS];

  assign st_wd  = s_q;
  assign acc_wd = (mode_q == lsrk_pkg::MODE_INIT) ? '0 : a_q;

  always_ff @(posedge clk_i) begin
    if (st_we) state_mem[addr] <= st_wd;
    if (acc_we) accum_mem[addr] <= acc_wd;
    if (start_we) start_mem[addr] <= s_q;
    if (state_q == lsrk_pkg::ST_READ) begin
      s_rd_q <= state_mem[addr];
      a_rd_q <= accum_mem[addr];
      t_rd_q <= start_mem[addr];
    end
  end

  // Control state: init flag, running maxima, output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_valid_q <= 1'b0;
      max_abs_q     <= '0;
      max_rel_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (state_q == lsrk_pkg::ST_WRITE && mode_q == lsrk_pkg::MODE_INIT) begin
        accum_valid_q <= 1'b1;
      end
      if (state_q == lsrk_pkg::ST_CALC && mode_q == lsrk_pkg::MODE_ERROR) begin
        max_abs_q <= (cand_abs > base_abs) ? cand_abs : base_abs;
        if (!(norm_sum > 34'sd0)) max_rel_q <= lsrk_pkg::SAT31;
        else if (restart_q) max_rel_q <= '0;
      end
      if (state_q == lsrk_pkg::ST_DIV && div_done && cand_rel_div > max_rel_q) begin
        max_rel_q <= cand_rel_div;
      end
      if (state_q == lsrk_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lsrk_pkg::ST_DONE && out_free) begin
      err_abs_q <= max_abs_q;
      err_rel_q <= max_rel_q;
      if (!rng_q) begin
        value_out_q <= '0;
      end else if (mode_q == lsrk_pkg::MODE_FINAL) begin
        value_out_q <= a_q;
      end else if (mode_q == lsrk_pkg::MODE_RDLOW) begin
        value_out_q <= accum_valid_q ? a_q : '0;
      end else begin
        value_out_q <= s_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign err_abs_o   = err_abs_q;
  assign err_rel_o   = err_rel_q;

  `LSRK_ASSERT_IMPL(a_div_start_err, div_start, mode_q == lsrk_pkg::MODE_ERROR)
  `LSRK_ASSERT_IMPL(a_ready_no_div, in_ready_o, !div_busy)
  `LSRK_ASSERT_IMPL(a_no_write_oor, st_we || acc_we || start_we, rng_q)
  `LSRK_ASSERT(a_valid_from_init, $rose(accum_valid_q) |-> $past(mode_q) == lsrk_pkg::MODE_INIT)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NELEM = 4096;
  localparam logic signed [67:0] HALF28 = 68'sd134217728;
  localparam logic signed [67:0] HALF24 = 68'sd8388608;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // Clock, reset and the ports of the engine.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] mode_i = '0;
  logic [11:0] element_index_i = '0;
  logic signed [31:0] value_in_i = '0;
  logic restart_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] value_out_o;
  logic [30:0] err_abs_o;
  logic [30:0] err_rel_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  low_storage_rk_stage_engine dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  typedef struct {
    lsrk_pkg::mode_e mode;
    logic [11:0] idx;
    logic signed [31:0] vin;
    logic restart;
  } op_t;

  typedef struct {
    logic signed [31:0] value;
    logic [30:0] abs_err;
    logic [30:0] rel_err;
  } answer_t;

  op_t pending_ops[$];
  answer_t expected_answers[$];
  bit failed = 1'b0;
  bit no_gaps = 1'b0;
  int beats_out = 0;

  // Shadow copy of the engine: coefficients and per-element stores.
  logic signed [31:0] k_a, k_b, k_c, k_beta, k_delta;
  logic [31:0] k_dt;
  logic [30:0] k_eps;
  logic signed [31:0] sh_state[NELEM];
  logic signed [31:0] sh_accum[NELEM];
  logic signed [31:0] sh_start[NELEM];
  bit has_state[NELEM];
  bit has_accum[NELEM];
  bit has_start[NELEM];
  bit sh_init_seen;
  logic [30:0] sh_max_abs, sh_max_rel;

  function automatic logic signed [31:0] clamp_q16(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -68'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Exact Q4.28 x Q16.16 dot product, rounded half up back to Q16.16.
  function automatic logic signed [31:0] dot_q16(
      input logic signed [31:0] c0, v0, c1, v1, c2, v2, c3, v3);
    logic signed [67:0] acc;
    acc = 68'(c0) * 68'(v0) + 68'(c1) * 68'(v1) + 68'(c2) * 68'(v2)
        + 68'(c3) * 68'(v3);
    return clamp_q16((acc + HALF28) >>> 28);
  endfunction

  // An operation may only touch store entries that already hold data.
  function automatic bit op_is_safe(input lsrk_pkg::mode_e m, input logic [11:0] i);
    case (m)
      lsrk_pkg::MODE_LOAD: return 1'b1;
      lsrk_pkg::MODE_READ, lsrk_pkg::MODE_INIT: return has_state[i];
      lsrk_pkg::MODE_UNDO: return has_start[i];
      lsrk_pkg::MODE_RDLOW: return !sh_init_seen || has_accum[i];
      default: return has_state[i] && has_accum[i] && has_start[i];
    endcase
  endfunction

  function automatic answer_t apply_op(input op_t op);
    answer_t r;
    logic signed [67:0] dp, diff, e, total, q;
    logic signed [31:0] d, inc;
    logic [30:0] ca, cr;
    int i;
    i = op.idx;
    r.value = sh_state[i];
    case (op.mode)
      lsrk_pkg::MODE_LOAD: begin
        sh_state[i] = op.vin;
        has_state[i] = 1'b1;
        r.value = op.vin;
      end
      lsrk_pkg::MODE_READ: ;
      lsrk_pkg::MODE_INIT: begin
        sh_accum[i] = '0;
        sh_start[i] = sh_state[i];
        has_accum[i] = 1'b1;
        has_start[i] = 1'b1;
        sh_init_seen = 1'b1;
      end
      lsrk_pkg::MODE_STAGE: begin
        dp = $signed({36'd0, k_dt}) * 68'(op.vin);
        d = clamp_q16((dp + HALF24) >>> 24);
        inc = dot_q16(k_delta, sh_state[i], 0, 0, 0, 0, 0, 0);
        sh_accum[i] = clamp_q16(68'(sh_accum[i]) + 68'(inc));
        sh_state[i] = dot_q16(k_a, sh_state[i], k_b, sh_accum[i], k_c, sh_start[i],
                              k_beta, d);
        r.value = sh_state[i];
      end
      lsrk_pkg::MODE_FINAL: begin
        sh_accum[i] = dot_q16(k_a, sh_state[i], k_b, sh_accum[i], k_c, sh_start[i],
                              0, 0);
        r.value = sh_accum[i];
      end
      lsrk_pkg::MODE_ERROR: begin
        diff = 68'(sh_state[i]) - 68'(sh_accum[i]);
        e = diff < 0 ? -diff : diff;
        total = 68'(sh_state[i]) + 68'(sh_start[i]) + $signed({37'd0, k_eps});
        if (op.restart) begin
          sh_max_abs = '0;
          sh_max_rel = '0;
        end
        ca = e > 68'sd2147483647 ? MAX31 : e[30:0];
        // A norm at or below zero pins the relative error at full scale.
        if (total <= 0) begin
          cr = MAX31;
        end else begin
          q = (e <<< 17) / total;
          cr = q > 68'sd2147483647 ? MAX31 : q[30:0];
        end
        if (ca > sh_max_abs) sh_max_abs = ca;
        if (cr > sh_max_rel) sh_max_rel = cr;
      end
      lsrk_pkg::MODE_UNDO: begin
        sh_state[i] = sh_start[i];
        r.value = sh_state[i];
      end
      default: r.value = sh_init_seen ? sh_accum[i] : '0;
    endcase
    r.abs_err = sh_max_abs;
    r.rel_err = sh_max_rel;
    return r;
  endfunction

  // Queue one beat; an operation that would read an empty entry becomes a load.
  task automatic queue_op(input lsrk_pkg::mode_e m, input int i,
                          input logic signed [31:0] v, input logic rs);
    op_t op;
    op.mode = op_is_safe(m, i[11:0]) ? m : lsrk_pkg::MODE_LOAD;
    op.idx = i[11:0];
    op.vin = v;
    op.restart = rs;
    pending_ops = {pending_ops, op};
    expected_answers = {expected_answers, apply_op(op)};
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    if (r < 9) return $urandom;
    return r[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // Input side: the driver takes beats from the pending queue.
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    op_t op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      busy = in_valid_i && !in_ready_o;
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          mode_i <= op.mode;
          element_index_i <= op.idx;
          value_in_i <= op.vin;
          restart_i <= op.restart;
          busy = 1'b1;
          in_gap = pick_gap();
        end
      end
      in_valid_i <= busy;
    end
  end

  // Output side: random back-pressure, plus one long hold-off so that the
  // engine fills up and has to stall its input.
  int out_gap = 0;
  int hold_cycles = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    bit rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        beats_out++;
        if (beats_out == 150) hold_cycles = 400;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected beat value=%0h", $time, value_out_o);
          failed = 1'b1;
        end else begin
          exp_a = expected_answers.pop_front();
          if (value_out_o !== exp_a.value) begin
            $display("%0t: value_out expected %0h actual %0h", $time, exp_a.value,
                     value_out_o);
            failed = 1'b1;
          end
          if (err_abs_o !== exp_a.abs_err) begin
            $display("%0t: err_abs expected %0h actual %0h", $time, exp_a.abs_err,
                     err_abs_o);
            failed = 1'b1;
          end
          if (err_rel_o !== exp_a.rel_err) begin
            $display("%0t: err_rel expected %0h actual %0h", $time, exp_a.rel_err,
                     err_rel_o);
            failed = 1'b1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rdy = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        out_gap = pick_gap();
      end
      out_ready_i <= rdy;
    end
  end

  task automatic write_reg(input lsrk_pkg::cfg_idx_e r, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      lsrk_pkg::CFG_COEF_A: k_a = v;
      lsrk_pkg::CFG_COEF_B: k_b = v;
      lsrk_pkg::CFG_COEF_C: k_c = v;
      lsrk_pkg::CFG_COEF_BETA: k_beta = v;
      lsrk_pkg::CFG_COEF_DELTA: k_delta = v;
      lsrk_pkg::CFG_STEP_DT: k_dt = v;
      default: k_eps = v[30:0];
    endcase
  endtask

  task automatic set_coefs(input logic [31:0] a, b, c, beta, delta, dt, eps);
    write_reg(lsrk_pkg::CFG_COEF_A, a);
    write_reg(lsrk_pkg::CFG_COEF_B, b);
    write_reg(lsrk_pkg::CFG_COEF_C, c);
    write_reg(lsrk_pkg::CFG_COEF_BETA, beta);
    write_reg(lsrk_pkg::CFG_COEF_DELTA, delta);
    write_reg(lsrk_pkg::CFG_STEP_DT, dt);
    write_reg(lsrk_pkg::CFG_ERR_EPS, eps);
  endtask

  // Wait until every queued beat went in and every answer came out, then give
  // the engine time to settle before the next register write.
  task automatic drain();
    while (pending_ops.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // A step on one element: load, init, stages, optional finalise, error check,
  // sometimes an undo, and reads of both values.
  task automatic queue_step(input int i);
    int n;
    queue_op(lsrk_pkg::MODE_LOAD, i, pick_value(), 1'b0);
    queue_op(lsrk_pkg::MODE_INIT, i, pick_value(), 1'b0);
    n = $urandom_range(1, 3);
    repeat (n) queue_op(lsrk_pkg::MODE_STAGE, i, pick_value(), 1'b0);
    if ($urandom_range(0, 1)) queue_op(lsrk_pkg::MODE_FINAL, i, pick_value(), 1'b0);
    queue_op(lsrk_pkg::MODE_ERROR, i, pick_value(), $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 2) == 0) queue_op(lsrk_pkg::MODE_UNDO, i, pick_value(), 1'b0);
    queue_op(lsrk_pkg::MODE_RDLOW, i, pick_value(), 1'b0);
    queue_op(lsrk_pkg::MODE_READ, i, pick_value(), 1'b0);
  endtask

  function automatic int pick_index();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 7);
    return $urandom_range(0, NELEM - 1);
  endfunction

  initial begin
    int phase;
    int target;
    k_a = '0; k_b = '0; k_c = '0; k_beta = '0; k_delta = '0; k_dt = '0; k_eps = '0;
    sh_init_seen = 1'b0;
    sh_max_abs = '0;
    sh_max_rel = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats under an ordinary third-order setting.
    set_coefs(32'h0800_0000, 32'h1000_0000, 32'hF800_0000, 32'h0555_5555,
              32'h0400_0000, 32'h0040_0000, 32'h0000_0100);
    // Read of the lower value before any init answers zero.
    queue_op(lsrk_pkg::MODE_RDLOW, 0, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_LOAD, 0, 32'sh7FFF_FFFF, 1'b0);
    queue_op(lsrk_pkg::MODE_LOAD, 4095, 32'sh8000_0000, 1'b0);
    queue_op(lsrk_pkg::MODE_READ, 0, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_INIT, 0, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_INIT, 4095, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_STAGE, 0, 32'sh7FFF_FFFF, 1'b0);
    queue_op(lsrk_pkg::MODE_STAGE, 4095, 32'sh8000_0000, 1'b0);
    queue_op(lsrk_pkg::MODE_FINAL, 0, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_ERROR, 0, 0, 1'b1);
    // Negative state and start give a norm at or below zero.
    queue_op(lsrk_pkg::MODE_ERROR, 4095, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_UNDO, 0, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_RDLOW, 4095, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_READ, 4095, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_ERROR, 0, 32'sh7FFF_FFFF, 1'b1);
    queue_op(lsrk_pkg::MODE_FINAL, 4095, 0, 1'b0);
    queue_op(lsrk_pkg::MODE_UNDO, 4095, 0, 1'b0);
    drain();

    // Random phases, each under its own setting; extremes come first.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        1: set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        2: set_coefs(32'h1000_0000, 32'h0000_0000, 32'h0000_0000, 32'h1000_0000,
                     32'h0000_0000, 32'h0100_0000, 32'h0000_0001);
        default: set_coefs($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
      endcase
      no_gaps = (phase == 3);
      target = expected_answers.size() + 275;
      while (expected_answers.size() < target) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_step(pick_index());
        end else begin
          queue_op(lsrk_pkg::mode_e'($urandom_range(0, 7)), pick_index(), pick_value(),
                   $urandom_range(0, 1));
        end
      end
      drain();
    end

    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/lsrk_pkg.sv
design/lsrk_div.sv
design/low_storage_rk_stage_engine.sv
verif/tb.sv
